[hw/rtl/m4xf_pkg.sv]
// ----------------------------------------------------------------------------
// m4xf_pkg
// Types, constants and helpers shared by the 4x4 matrix transform engine.
// ----------------------------------------------------------------------------
package m4xf_pkg;

   localparam int FRAC_BITS = 16;
   localparam int ELEM_W    = 32;
   localparam int THR_W     = 31;
   localparam int PROD_W    = 2 * ELEM_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int DIM       = 4;
   localparam int IDX_W     = 2;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_COL  = 2'd1;
   localparam logic [1:0] OP_ROW  = 2'd2;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(7);

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef elem_type                 vec_type [DIM];
   typedef logic [THR_W-1:0]         thr_type;

   typedef struct packed {
      logic adv;     // pipeline advances this cycle
      logic flush;   // item in the sum stage is a row multiply
   } lane_ctl_type;

   typedef struct packed {
      elem_type value;
      logic     clip;
   } lane_res_type;

   // True when |v| is strictly below the threshold.
   function automatic logic below_thr(elem_type v, thr_type t);
      logic [ELEM_W-1:0] mag;
      mag = v[ELEM_W-1] ? ELEM_W'(-v) : ELEM_W'(v);
      return mag < {1'b0, t};
   endfunction

endpackage

[hw/rtl/m4xf_lane.sv]
// ----------------------------------------------------------------------------
// m4xf_lane
// One result component: four products, exact sum, shift, saturate, flush.
// ----------------------------------------------------------------------------
module m4xf_lane (
   input  logic                   clock,
   input  m4xf_pkg::lane_ctl_type ctl,
   input  m4xf_pkg::vec_type      mat_vec,
   input  m4xf_pkg::vec_type      in_vec,
   input  m4xf_pkg::thr_type      thr,
   output m4xf_pkg::lane_res_type res
);
   import m4xf_pkg::*;

   logic signed [PROD_W-1:0] prod_ff [DIM];
   logic signed [PROD_W-1:0] prod_in [DIM];
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SUM_W-1:0]  shifted;
   logic                     all_zero;
   logic                     all_one;
   logic                     clip;
   elem_type                 sat_val;

   always_comb begin
      for (int j = 0; j < DIM; j++) begin
         prod_in[j] = PROD_W'(mat_vec[j]) * PROD_W'(in_vec[j]);
      end
   end

   assign sum_in = (SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]))
                 + (SUM_W'(prod_ff[2]) + SUM_W'(prod_ff[3]));

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         for (int j = 0; j < DIM; j++) begin
            prod_ff[j] <= prod_in[j];
         end
         sum_ff <= sum_in;
      end
   end

   assign shifted  = sum_ff >>> FRAC_BITS;
   assign all_zero = ~|shifted[SUM_W-1:ELEM_W-1];
   assign all_one  = &shifted[SUM_W-1:ELEM_W-1];
   assign clip     = !(all_zero || all_one);

   always_comb begin
      if (!clip) begin
         sat_val = shifted[ELEM_W-1:0];
      end else if (shifted[SUM_W-1]) begin
         sat_val = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(ELEM_W-1){1'b1}}};
      end
      res.clip  = clip;
      res.value = (ctl.flush && below_thr(sat_val, thr)) ? '0 : sat_val;
   end

endmodule

[hw/rtl/matrix4_transform_engine.sv]
// ----------------------------------------------------------------------------
// matrix4_transform_engine
// Holds a signed Q16.16 4x4 matrix and, per item, loads one element
// (small magnitudes flushed to zero), returns M times a column vector, or
// returns a row vector times M with small results flushed. Four lanes with
// four multipliers each work in parallel; a transform's result passes the
// product and sum registers, is saturated and presented from the output
// buffer. The block takes one item every cycle while req_ready is high. A load has
// no result and is seen by the very next item. A two-entry output buffer
// keeps req_ready independent of rsp_ready; req_ready drops only while that
// buffer is full. The threshold register accepts a write in any cycle.
// ----------------------------------------------------------------------------
module matrix4_transform_engine (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_opcode,
   input  logic [1:0]          req_row_index,
   input  logic [1:0]          req_col_index,
   input  logic signed [31:0]  req_element_value,
   input  logic signed [31:0]  req_in_x,
   input  logic signed [31:0]  req_in_y,
   input  logic signed [31:0]  req_in_z,
   input  logic signed [31:0]  req_in_w,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_res_x,
   output logic signed [31:0]  rsp_res_y,
   output logic signed [31:0]  rsp_res_z,
   output logic signed [31:0]  rsp_res_w,
   output logic                rsp_saturated,

   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [30:0]         csr_flush_threshold
);
   import m4xf_pkg::*;

   localparam int NUM_ELEM = DIM * DIM;

   elem_type     mat_ff [NUM_ELEM];
   thr_type      thr_ff;

   logic         p_valid_ff, p_valid_in;
   logic         p_flush_ff;
   logic         s_valid_ff;
   logic         s_flush_ff;

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   lane_res_type out_ff [DIM];
   lane_res_type out_in [DIM];
   lane_res_type skid_ff [DIM];
   lane_res_type skid_in [DIM];

   logic         en;
   logic         req_xfer;
   logic         is_xform;
   logic         load_xfer;
   logic [3:0]   load_idx;
   logic         take;
   logic         pop;

   vec_type      in_vec;
   vec_type      lane_mat [DIM];
   lane_ctl_type lane_ctl;
   lane_res_type lane_res [DIM];

   assign en        = !skid_valid_ff;
   assign req_ready = en;
   assign csr_ready = 1'b1;
   assign req_xfer  = req_valid && req_ready;
   assign is_xform  = (req_opcode == OP_COL) || (req_opcode == OP_ROW);
   assign load_xfer = req_xfer && (req_opcode == OP_LOAD);
   assign load_idx  = {req_row_index, req_col_index};
   assign p_valid_in = req_xfer && is_xform;

   assign in_vec[0] = req_in_x;
   assign in_vec[1] = req_in_y;
   assign in_vec[2] = req_in_z;
   assign in_vec[3] = req_in_w;

   // Lane i takes row i for a column transform, column i for a row multiply.
   always_comb begin
      for (int i = 0; i < DIM; i++) begin
         for (int j = 0; j < DIM; j++) begin
            lane_mat[i][j] = (req_opcode == OP_ROW) ? mat_ff[j*DIM + i]
                                                    : mat_ff[i*DIM + j];
         end
      end
   end

   assign lane_ctl.adv   = en;
   assign lane_ctl.flush = s_flush_ff;

   for (genvar g = 0; g < DIM; g++) begin : g_lane
      m4xf_lane u_lane (
         .clock   (clock),
         .ctl     (lane_ctl),
         .mat_vec (lane_mat[g]),
         .in_vec  (in_vec),
         .thr     (thr_ff),
         .res     (lane_res[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_ELEM; k++) begin
            mat_ff[k] <= '0;
         end
      end else if (load_xfer) begin
         mat_ff[load_idx] <= below_thr(req_element_value, thr_ff) ? '0
                                                                  : req_element_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_flush_threshold;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= p_valid_in;
         s_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_flush_ff <= (req_opcode == OP_ROW);
         s_flush_ff <= p_flush_ff;
      end
   end

   // Merge of the four lanes into a two-entry output buffer.
   assign take = en && s_valid_ff;
   assign pop  = out_valid_ff && rsp_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (take) begin
            out_in = lane_res;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (take) begin
         if (out_valid_ff) begin
            skid_in       = lane_res;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = lane_res;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_res_x     = out_ff[0].value;
   assign rsp_res_y     = out_ff[1].value;
   assign rsp_res_z     = out_ff[2].value;
   assign rsp_res_w     = out_ff[3].value;
   assign rsp_saturated = out_ff[0].clip || out_ff[1].clip
                       || out_ff[2].clip || out_ff[3].clip;

`ifndef ASSERT_OFF
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a head entry");

   a_full_blocks_req: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !req_ready)
      else $error("request taken while output buffer full");

   a_pipe_moves: assert property (@(posedge clock) disable iff (reset)
      (p_valid_ff && en) |=> s_valid_ff)
      else $error("product stage item lost");

   a_sum_lands: assert property (@(posedge clock) disable iff (reset)
      (s_valid_ff && en) |=> out_valid_ff)
      else $error("sum stage item not buffered");

   a_load_flush: assert property (@(posedge clock) disable iff (reset)
      (load_xfer && below_thr(req_element_value, thr_ff))
         |=> (mat_ff[$past(load_idx)] == '0))
      else $error("small load value not flushed");
`endif

endmodule
